// ----- rtl/range_min_segment_tree_macros.svh -----
// Assertion macros for the range minimum tree checker.
// Both macros sample on clk and are disabled while rst_n is low.
`ifndef RANGE_MIN_SEGMENT_TREE_MACROS_SVH
`define RANGE_MIN_SEGMENT_TREE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RMST_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("range_min_segment_tree: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define RMST_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("range_min_segment_tree: next-cycle check failed");

`endif

// ----- rtl/rmst_pkg.sv -----
package rmst_pkg;

    localparam int LEAVES_DEF = 1024;
    localparam int NODE_W     = 32;
    localparam int IDX_W      = 10;
    localparam int CFG_W      = 11;

    localparam logic [CFG_W-1:0]         ELEMS_RESET = 11'd1024;
    localparam logic signed [NODE_W-1:0] NODE_INIT   = 32'sh7FFF_FFFF;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;
    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [IDX_W-1:0]         element_index;
        logic signed [NODE_W-1:0] element_value;
        logic [IDX_W-1:0]         range_first;
        logic [IDX_W-1:0]         range_last;
    } req_t;

    typedef struct packed {
        logic signed [NODE_W-1:0] min_value;
        logic                     status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF,
        ST_CLIMB,
        ST_QLOOP,
        ST_QLO,
        ST_QHI
    } state_t;

    typedef enum logic [1:0] {
        FIN_WRITE,
        FIN_QUERY,
        FIN_ERROR
    } fin_t;

    typedef struct packed {
        logic clear_step;
        logic load;
        logic leaf_write;
        logic climb;
        logic read_lo;
        logic read_hi;
        logic take_lo;
        logic take_hi;
        logic shift;
        logic finish;
        fin_t fin_code;
    } ctl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic req_ok;
        logic req_query;
        logic parent_root;
        logic lo_lt_hi;
        logic lo_odd;
        logic hi_odd;
    } dp_stat_t;

    function automatic logic signed [NODE_W-1:0] smin(
        input logic signed [NODE_W-1:0] a,
        input logic signed [NODE_W-1:0] b
    );
        return (a < b) ? a : b;
    endfunction

endpackage

// ----- rtl/rmst_ram.sv -----
module rmst_ram #(
    parameter int WIDTH = rmst_pkg::NODE_W,
    parameter int DEPTH = 2 * rmst_pkg::LEAVES_DEF
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/rmst_ctrl.sv -----
module rmst_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  rmst_pkg::dp_stat_t  stat,
    output rmst_pkg::ctl_cmd_t  cmd,
    output logic                busy
);

    rmst_pkg::state_t state_reg;
    rmst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rmst_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        cmd.fin_code = rmst_pkg::FIN_WRITE;
        case (state_reg)
            rmst_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = rmst_pkg::ST_IDLE;
                end
            end
            rmst_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    if (!stat.req_ok)
                    begin
                        cmd.finish   = 1'b1;
                        cmd.fin_code = rmst_pkg::FIN_ERROR;
                    end
                    else
                    begin
                        cmd.load   = 1'b1;
                        state_next = stat.req_query ? rmst_pkg::ST_QLOOP
                                                    : rmst_pkg::ST_LEAF;
                    end
                end
            end
            rmst_pkg::ST_LEAF:
            begin
                cmd.leaf_write = 1'b1;
                state_next     = rmst_pkg::ST_CLIMB;
            end
            rmst_pkg::ST_CLIMB:
            begin
                cmd.climb = 1'b1;
                if (stat.parent_root)
                begin
                    cmd.finish   = 1'b1;
                    cmd.fin_code = rmst_pkg::FIN_WRITE;
                    state_next   = rmst_pkg::ST_IDLE;
                end
            end
            rmst_pkg::ST_QLOOP:
            begin
                if (!stat.lo_lt_hi)
                begin
                    cmd.finish   = 1'b1;
                    cmd.fin_code = rmst_pkg::FIN_QUERY;
                    state_next   = rmst_pkg::ST_IDLE;
                end
                else if (stat.lo_odd)
                begin
                    cmd.read_lo = 1'b1;
                    state_next  = rmst_pkg::ST_QLO;
                end
                else if (stat.hi_odd)
                begin
                    cmd.read_hi = 1'b1;
                    state_next  = rmst_pkg::ST_QHI;
                end
                else
                begin
                    cmd.shift = 1'b1;
                end
            end
            rmst_pkg::ST_QLO:
            begin
                // fold left node, then either fetch the right one or go up a level
                cmd.take_lo = 1'b1;
                if (stat.hi_odd)
                begin
                    cmd.read_hi = 1'b1;
                    state_next  = rmst_pkg::ST_QHI;
                end
                else
                begin
                    cmd.shift  = 1'b1;
                    state_next = rmst_pkg::ST_QLOOP;
                end
            end
            rmst_pkg::ST_QHI:
            begin
                cmd.take_hi = 1'b1;
                cmd.shift   = 1'b1;
                state_next  = rmst_pkg::ST_QLOOP;
            end
            default:
            begin
                state_next = rmst_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != rmst_pkg::ST_IDLE);

endmodule

// ----- rtl/rmst_datapath.sv -----
module rmst_datapath #(
    parameter int LEAVES = rmst_pkg::LEAVES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  rmst_pkg::req_t             request,
    input  logic                       cfg_valid,
    input  logic [rmst_pkg::CFG_W-1:0] cfg_data,
    input  rmst_pkg::ctl_cmd_t         cmd,
    output rmst_pkg::dp_stat_t         stat,
    output logic                       done,
    output rmst_pkg::rsp_t             result
);

    localparam int DEPTH = 2 * LEAVES;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = AW + 1;
    localparam logic [AW-1:0] LAST_NODE = AW'(DEPTH - 1);
    localparam logic [31:0]   LEAVES_U  = 32'(LEAVES);

    logic [rmst_pkg::CFG_W-1:0] elems_reg, elems_next;
    logic [AW-1:0]              clr_reg, clr_next;
    logic                       done_reg, done_next;
    rmst_pkg::rsp_t             result_reg, result_next;

    logic [AW-1:0]                      p_reg, p_next;
    logic signed [rmst_pkg::NODE_W-1:0] val_reg, val_next;
    logic signed [rmst_pkg::NODE_W-1:0] cur_reg, cur_next;
    logic signed [rmst_pkg::NODE_W-1:0] acc_reg, acc_next;
    logic [QW-1:0]                      lo_reg, lo_next;
    logic [QW-1:0]                      hi_reg, hi_next;

    logic                               wr_en;
    logic [AW-1:0]                      wr_addr;
    logic [rmst_pkg::NODE_W-1:0]        wr_data;
    logic                               rd_en;
    logic [AW-1:0]                      rd_addr;
    logic [rmst_pkg::NODE_W-1:0]        rd_data;

    logic                               idx_ok;
    logic                               rng_ok;
    logic [31:0]                        leaf_sum;
    logic [31:0]                        lo_sum;
    logic [31:0]                        hi_sum;
    logic [AW-1:0]                      parent;
    logic [QW-1:0]                      hi_dec;
    logic [QW-1:0]                      lo_step;
    logic [QW-1:0]                      hi_step;
    logic signed [rmst_pkg::NODE_W-1:0] node_min;
    logic signed [rmst_pkg::NODE_W-1:0] acc_min;

    rmst_ram #(
        .WIDTH (rmst_pkg::NODE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // element counts above LEAVES act as LEAVES
    assign idx_ok = ({1'b0, request.element_index} < elems_reg)
                 && (32'(request.element_index) < LEAVES_U);
    assign rng_ok = (request.range_first <= request.range_last)
                 && ({1'b0, request.range_last} < elems_reg)
                 && (32'(request.range_last) < LEAVES_U);

    assign leaf_sum = LEAVES_U + 32'(request.element_index);
    assign lo_sum   = LEAVES_U + 32'(request.range_first);
    assign hi_sum   = LEAVES_U + 32'(request.range_last) + 32'd1;

    assign parent   = p_reg >> 1;
    assign hi_dec   = hi_reg - QW'(1);
    assign node_min = rmst_pkg::smin(cur_reg, $signed(rd_data));
    assign acc_min  = rmst_pkg::smin(acc_reg, $signed(rd_data));

    always_comb
    begin
        stat.clear_last  = (clr_reg == LAST_NODE);
        stat.req_ok      = (request.action == rmst_pkg::ACT_WRITE) ? idx_ok : rng_ok;
        stat.req_query   = (request.action == rmst_pkg::ACT_QUERY);
        stat.parent_root = (parent == AW'(1));
        stat.lo_lt_hi    = (lo_reg < hi_reg);
        stat.lo_odd      = lo_reg[0];
        stat.hi_odd      = hi_reg[0];
    end

    // memory port steering
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = clr_reg;
        wr_data = rmst_pkg::NODE_INIT;
        rd_en   = 1'b0;
        rd_addr = p_reg ^ AW'(1);
        if (cmd.clear_step)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.leaf_write)
        begin
            wr_en   = 1'b1;
            wr_addr = p_reg;
            wr_data = val_reg;
            rd_en   = 1'b1;
        end
        else if (cmd.climb)
        begin
            wr_en   = 1'b1;
            wr_addr = parent;
            wr_data = node_min;
            rd_en   = !stat.parent_root;
            rd_addr = parent ^ AW'(1);
        end
        if (cmd.read_lo)
        begin
            rd_en   = 1'b1;
            rd_addr = lo_reg[AW-1:0];
        end
        else if (cmd.read_hi)
        begin
            rd_en   = 1'b1;
            rd_addr = hi_dec[AW-1:0];
        end
    end

    always_comb
    begin
        elems_next = cfg_valid ? cfg_data : elems_reg;
        clr_next   = cmd.clear_step ? clr_reg + AW'(1) : clr_reg;

        p_next   = p_reg;
        val_next = val_reg;
        cur_next = cur_reg;
        acc_next = acc_reg;

        lo_step = cmd.take_lo ? lo_reg + QW'(1) : lo_reg;
        hi_step = cmd.read_hi ? hi_dec : hi_reg;
        lo_next = cmd.shift ? lo_step >> 1 : lo_step;
        hi_next = cmd.shift ? hi_step >> 1 : hi_step;

        if (cmd.load)
        begin
            p_next   = leaf_sum[AW-1:0];
            val_next = request.element_value;
            lo_next  = lo_sum[QW-1:0];
            hi_next  = hi_sum[QW-1:0];
            acc_next = rmst_pkg::NODE_INIT;
        end
        if (cmd.leaf_write)
        begin
            cur_next = val_reg;
        end
        if (cmd.climb)
        begin
            cur_next = node_min;
            p_next   = parent;
        end
        if (cmd.take_lo || cmd.take_hi)
        begin
            acc_next = acc_min;
        end

        done_next   = cmd.finish;
        result_next = result_reg;
        if (cmd.finish)
        begin
            case (cmd.fin_code)
                rmst_pkg::FIN_WRITE:
                begin
                    result_next.min_value = '0;
                    result_next.status    = rmst_pkg::STATUS_OK;
                end
                rmst_pkg::FIN_QUERY:
                begin
                    result_next.min_value = acc_reg;
                    result_next.status    = rmst_pkg::STATUS_OK;
                end
                default:
                begin
                    result_next.min_value = '0;
                    result_next.status    = rmst_pkg::STATUS_ERR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elems_reg <= rmst_pkg::ELEMS_RESET;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            elems_reg <= elems_next;
            clr_reg   <= clr_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        p_reg      <= p_next;
        val_reg    <= val_next;
        cur_reg    <= cur_next;
        acc_reg    <= acc_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ----- rtl/range_min_segment_tree.sv -----
// Write: the leaf is written, then each parent up to the root is updated; done follows the root update.
// Query: each level folds in any odd end node, then moves up; done follows once the range closes.
// Rejected item: done the cycle after accept. One item in flight; start is taken again when done shows.
// done is a one-cycle strobe; result holds until the next finish; the receiver cannot stall them.
// Reset: elements_in_use goes to 1024 and a clearing pass sets all 2*LEAVES nodes to the
// maximum signed value while busy stays high.
module range_min_segment_tree #(
    parameter int LEAVES = rmst_pkg::LEAVES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  rmst_pkg::req_t             request,
    output logic                       done,
    output rmst_pkg::rsp_t             result,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [rmst_pkg::CFG_W-1:0] cfg_data
);

    rmst_pkg::ctl_cmd_t cmd;
    rmst_pkg::dp_stat_t stat;
    logic               cfg_transfer;

    assign cfg_ready    = 1'b1;
    assign cfg_transfer = cfg_valid && cfg_ready;

    rmst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rmst_datapath #(
        .LEAVES (LEAVES)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .request   (request),
        .cfg_valid (cfg_transfer),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .done      (done),
        .result    (result)
    );

endmodule

// ----- rtl/rmst_checker.sv -----
`include "range_min_segment_tree_macros.svh"

module rmst_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input rmst_pkg::req_t             request,
    input logic                       done,
    input rmst_pkg::rsp_t             result
);

    logic accepted;
    logic reversed_query;

    assign accepted       = start && !busy;
    assign reversed_query = accepted && (request.action == rmst_pkg::ACT_QUERY)
                         && (request.range_first > request.range_last);

    // an accepted item either keeps the block busy or answers at once
    `RMST_ASSERT_NEXT(a_accept_progress, accepted, busy || done)

    // no result appears out of an idle cycle without a transfer
    `RMST_ASSERT_NEXT(a_no_spurious_done, !busy && !start, !done)

    // a reversed range is rejected on the next cycle
    `RMST_ASSERT_NEXT(a_reversed_rejected, reversed_query,
                      done && (result.status == rmst_pkg::STATUS_ERR))

    // rejected items carry a zero value
    `RMST_ASSERT_NOW(a_error_zero, done && (result.status == rmst_pkg::STATUS_ERR),
                     result.min_value == '0)

endmodule

bind range_min_segment_tree rmst_checker u_rmst_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .request   (request),
    .done      (done),
    .result    (result)
);
